>>> design/tsa_pkg.sv
// Shared types and constants for the tiled surface address pipeline.
package tsa_pkg;

    localparam int MAX_EXTENT   = 16384;
    localparam int ES_MAX       = 4;
    localparam int COORD_W      = 14;
    localparam int EXTENT_W     = 15;
    localparam int ES_W         = 3;
    localparam int MASK_WORD_W  = 64;
    localparam int SWZ_BITS     = 16;
    localparam int INBLK_W      = 8;
    localparam int OFFSET_W     = 32;
    localparam int PROD_W       = COORD_W + EXTENT_W;
    localparam int SUM_W        = PROD_W + 1;
    localparam int ALIGN_LOG2   = 8;
    localparam int CFG_ADDR_W   = 3;
    localparam int SHIFTLOG_W   = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_LINEAR_MODE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ELEM_SIZE_LOG = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SURF_WIDTH    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SURF_HEIGHT   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_X_MASKS_LO    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_X_MASKS_HI    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_MASKS_LO    = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_MASKS_HI    = 3'd7;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SETUP = 2'd2
    } t_status;

    typedef struct packed {
        logic                        linear;
        logic [ES_W-1:0]             es_log2;
        logic [EXTENT_W-1:0]         width;
        logic [EXTENT_W-1:0]         height;
        logic [2*MASK_WORD_W-1:0]    x_masks;
        logic [2*MASK_WORD_W-1:0]    y_masks;
    } t_cfg;

    typedef struct packed {
        logic                        valid;
        t_status                     status;
        logic                        linear;
        logic [ES_W-1:0]             es_log2;
        logic [COORD_W-1:0]          mul_a;
        logic [EXTENT_W-1:0]         mul_b;
        logic [COORD_W-1:0]          addend;
        logic [INBLK_W-1:0]          xi;
        logic [INBLK_W-1:0]          yi;
    } t_stage_a;

    typedef struct packed {
        logic                        valid;
        t_status                     status;
        logic                        linear;
        logic [ES_W-1:0]             es_log2;
        logic [PROD_W-1:0]           prod;
        logic [COORD_W-1:0]          addend;
        logic [SWZ_BITS-1:0]         swz;
    } t_stage_b;

endpackage

>>> design/tsa_cfg_regs.sv
// Configuration register file for the surface setup and swizzle masks.
module tsa_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tsa_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [tsa_pkg::MASK_WORD_W-1:0]    i_cfg_data,
    output tsa_pkg::t_cfg                      o_cfg
);

    logic                              r_linear;
    logic [tsa_pkg::ES_W-1:0]          r_es_log2;
    logic [tsa_pkg::EXTENT_W-1:0]      r_width;
    logic [tsa_pkg::EXTENT_W-1:0]      r_height;
    logic [tsa_pkg::MASK_WORD_W-1:0]   r_xm_lo;
    logic [tsa_pkg::MASK_WORD_W-1:0]   r_xm_hi;
    logic [tsa_pkg::MASK_WORD_W-1:0]   r_ym_lo;
    logic [tsa_pkg::MASK_WORD_W-1:0]   r_ym_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_linear  <= 1'b0;
            r_es_log2 <= 3'd2;
            r_width   <= 15'd64;
            r_height  <= 15'd64;
            r_xm_lo   <= '0;
            r_xm_hi   <= '0;
            r_ym_lo   <= '0;
            r_ym_hi   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tsa_pkg::REG_LINEAR_MODE:   r_linear  <= i_cfg_data[0];
                tsa_pkg::REG_ELEM_SIZE_LOG: r_es_log2 <= i_cfg_data[tsa_pkg::ES_W-1:0];
                tsa_pkg::REG_SURF_WIDTH:    r_width   <= i_cfg_data[tsa_pkg::EXTENT_W-1:0];
                tsa_pkg::REG_SURF_HEIGHT:   r_height  <= i_cfg_data[tsa_pkg::EXTENT_W-1:0];
                tsa_pkg::REG_X_MASKS_LO:    r_xm_lo   <= i_cfg_data;
                tsa_pkg::REG_X_MASKS_HI:    r_xm_hi   <= i_cfg_data;
                tsa_pkg::REG_Y_MASKS_LO:    r_ym_lo   <= i_cfg_data;
                tsa_pkg::REG_Y_MASKS_HI:    r_ym_hi   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg.linear  = r_linear;
    assign o_cfg.es_log2 = r_es_log2;
    assign o_cfg.width   = r_width;
    assign o_cfg.height  = r_height;
    assign o_cfg.x_masks = {r_xm_hi, r_xm_lo};
    assign o_cfg.y_masks = {r_ym_hi, r_ym_lo};

endmodule

>>> design/tsa_decode.sv
// First stage: setup and range checks, block geometry, multiplier operands.
module tsa_decode (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [tsa_pkg::COORD_W-1:0]     i_x_coord,
    input  logic [tsa_pkg::COORD_W-1:0]     i_y_coord,
    input  tsa_pkg::t_cfg                   i_cfg,
    output tsa_pkg::t_stage_a               o_stage
);

    logic                                   setup_bad;
    logic                                   range_bad;
    logic [tsa_pkg::EXTENT_W+3:0]           row_bytes;
    logic [tsa_pkg::SHIFTLOG_W-1:0]         bw_log;
    logic [tsa_pkg::SHIFTLOG_W-1:0]         bh_log;
    logic [tsa_pkg::INBLK_W-1:0]            bw_mask;
    logic [tsa_pkg::INBLK_W-1:0]            bh_mask;
    logic [tsa_pkg::EXTENT_W:0]             pitch_sum;
    logic [tsa_pkg::EXTENT_W-1:0]           pitch;
    logic [tsa_pkg::COORD_W-1:0]            x_blk;
    logic [tsa_pkg::COORD_W-1:0]            y_blk;
    tsa_pkg::t_stage_a                      n_stage;
    tsa_pkg::t_stage_a                      r_stage;

    always_comb begin
        case (i_cfg.es_log2)
            3'd0: begin bw_log = 4'd8; bh_log = 4'd8; end
            3'd1: begin bw_log = 4'd8; bh_log = 4'd7; end
            3'd2: begin bw_log = 4'd7; bh_log = 4'd7; end
            3'd3: begin bw_log = 4'd7; bh_log = 4'd6; end
            3'd4: begin bw_log = 4'd6; bh_log = 4'd6; end
            default: begin bw_log = 4'd8; bh_log = 4'd8; end
        endcase
    end

    assign bw_mask = tsa_pkg::INBLK_W'(8'hff >> (4'd8 - bw_log));
    assign bh_mask = tsa_pkg::INBLK_W'(8'hff >> (4'd8 - bh_log));

    assign row_bytes = {4'b0, i_cfg.width} << i_cfg.es_log2;

    assign setup_bad = (i_cfg.width == '0) || (i_cfg.height == '0)
                    || (i_cfg.width > tsa_pkg::EXTENT_W'(tsa_pkg::MAX_EXTENT))
                    || (i_cfg.height > tsa_pkg::EXTENT_W'(tsa_pkg::MAX_EXTENT))
                    || (i_cfg.es_log2 > tsa_pkg::ES_W'(tsa_pkg::ES_MAX))
                    || (i_cfg.linear && (row_bytes[tsa_pkg::ALIGN_LOG2-1:0] != '0));

    assign range_bad = ({1'b0, i_x_coord} >= i_cfg.width)
                    || ({1'b0, i_y_coord} >= i_cfg.height);

    assign pitch_sum = {1'b0, i_cfg.width} + (tsa_pkg::EXTENT_W+1)'(bw_mask);
    assign pitch     = tsa_pkg::EXTENT_W'(pitch_sum >> bw_log);
    assign x_blk     = i_x_coord >> bw_log;
    assign y_blk     = i_y_coord >> bh_log;

    always_comb begin
        n_stage.valid   = i_valid;
        n_stage.linear  = i_cfg.linear;
        n_stage.es_log2 = i_cfg.es_log2;
        n_stage.xi      = i_x_coord[tsa_pkg::INBLK_W-1:0] & bw_mask;
        n_stage.yi      = i_y_coord[tsa_pkg::INBLK_W-1:0] & bh_mask;
        if (setup_bad) begin
            n_stage.status = tsa_pkg::ST_SETUP;
        end else if (range_bad) begin
            n_stage.status = tsa_pkg::ST_RANGE;
        end else begin
            n_stage.status = tsa_pkg::ST_OK;
        end
        if (i_cfg.linear) begin
            n_stage.mul_a  = i_y_coord;
            n_stage.mul_b  = i_cfg.width;
            n_stage.addend = i_x_coord;
        end else begin
            n_stage.mul_a  = y_blk;
            n_stage.mul_b  = pitch;
            n_stage.addend = x_blk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

>>> design/tsa_mul.sv
// Second stage: row product and swizzle parity bits.
module tsa_mul (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tsa_pkg::t_stage_a    i_stage,
    input  tsa_pkg::t_cfg        i_cfg,
    output tsa_pkg::t_stage_b    o_stage
);

    logic [tsa_pkg::SWZ_BITS-1:0]  swz;
    tsa_pkg::t_stage_b             n_stage;
    tsa_pkg::t_stage_b             r_stage;

    always_comb begin
        for (int k = 0; k < tsa_pkg::SWZ_BITS; k++) begin
            swz[k] = (^(i_stage.xi & i_cfg.x_masks[k*tsa_pkg::INBLK_W +: tsa_pkg::INBLK_W]))
                   ^ (^(i_stage.yi & i_cfg.y_masks[k*tsa_pkg::INBLK_W +: tsa_pkg::INBLK_W]));
        end
    end

    always_comb begin
        n_stage.valid   = i_stage.valid;
        n_stage.status  = i_stage.status;
        n_stage.linear  = i_stage.linear;
        n_stage.es_log2 = i_stage.es_log2;
        n_stage.prod    = tsa_pkg::PROD_W'(i_stage.mul_a) * tsa_pkg::PROD_W'(i_stage.mul_b);
        n_stage.addend  = i_stage.addend;
        n_stage.swz     = swz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

>>> design/tsa_merge.sv
// Third stage: final add, scale or swizzle merge, and result register.
module tsa_merge (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tsa_pkg::t_stage_b                i_stage,
    output logic                             o_done,
    output logic [tsa_pkg::OFFSET_W-1:0]     o_byte_offset,
    output logic [1:0]                       o_status
);

    logic [tsa_pkg::SUM_W-1:0]      sum;
    logic [tsa_pkg::OFFSET_W-1:0]   n_offset;
    logic                           r_done;
    logic [tsa_pkg::OFFSET_W-1:0]   r_offset;
    tsa_pkg::t_status               r_status;

    assign sum = tsa_pkg::SUM_W'(i_stage.prod) + tsa_pkg::SUM_W'(i_stage.addend);

    always_comb begin
        if (i_stage.status != tsa_pkg::ST_OK) begin
            n_offset = '0;
        end else if (i_stage.linear) begin
            n_offset = tsa_pkg::OFFSET_W'(sum) << i_stage.es_log2;
        end else begin
            n_offset = {sum[tsa_pkg::SWZ_BITS-1:0], i_stage.swz};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_stage.valid;
        end
        r_offset <= n_offset;
        r_status <= i_stage.status;
    end

    assign o_done        = r_done;
    assign o_byte_offset = r_offset;
    assign o_status      = r_status;

endmodule

>>> design/tiled_surface_address.sv
// Top level of the tiled surface address generator.
// The start beat passes through the decode, multiply and merge registers to the done strobe.
// Throughput: one coordinate per cycle; the pipeline never stalls, busy stays low.
// The 14x15 row multiply in the middle stage sets the stage depth.
// Reset clears the pipeline valid bits and loads the register reset values.
module tiled_surface_address (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [tsa_pkg::COORD_W-1:0]        i_x_coord,
    input  logic [tsa_pkg::COORD_W-1:0]        i_y_coord,
    input  logic                               i_cfg_we,
    input  logic [tsa_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [tsa_pkg::MASK_WORD_W-1:0]    i_cfg_data,
    output logic                               o_done,
    output logic [tsa_pkg::OFFSET_W-1:0]       o_byte_offset,
    output logic [1:0]                         o_status
);

    tsa_pkg::t_cfg      cfg;
    tsa_pkg::t_stage_a  stage_a;
    tsa_pkg::t_stage_b  stage_b;

    assign o_busy = 1'b0;

    tsa_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    tsa_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_start & ~o_busy),
        .i_x_coord (i_x_coord),
        .i_y_coord (i_y_coord),
        .i_cfg     (cfg),
        .o_stage   (stage_a)
    );

    tsa_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (stage_a),
        .i_cfg   (cfg),
        .o_stage (stage_b)
    );

    tsa_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stage       (stage_b),
        .o_done        (o_done),
        .o_byte_offset (o_byte_offset),
        .o_status      (o_status)
    );

endmodule
